/* src/brq_pkg.sv */
// Package for the bucketed rank query engine.
// Holds field widths, operation codes and default sizes; no dependencies.
package brq_pkg;

    localparam int MAX_LENGTH_DEF = 65536;
    localparam int BUCKET_SIZE    = 256;
    localparam int SYMBOLS        = 256;

    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int POS_W   = 16;
    localparam int COUNT_W = 17;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

endpackage

/* src/brq_if.sv */
// Stream interfaces for the request and result channels of the rank engine.
// Depends on brq_pkg for field widths.
interface brq_req_if import brq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;

    modport source (output valid, output op, output symbol, output position, input ready);
    modport sink   (input valid, input op, input symbol, input position, output ready);
endinterface

interface brq_rsp_if import brq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] rank_count;
    logic               out_of_range;

    modport source (output valid, output rank_count, output out_of_range, input ready);
    modport sink   (input valid, input rank_count, input out_of_range, output ready);
endinterface

/* src/bwt_bucketed_rank_query.sv */
// Top level of the bucketed rank query engine over an 8-bit symbol string.
// Depends on brq_pkg and the stream interfaces in brq_if.sv.
//
// One request is handled at a time; req.ready is high only while the engine
// is idle. A load that starts a new bucket first copies the 256 running
// counts into the bucket table one per cycle through the running-count read
// port. A query reads two bucket counts and then decides.
// When a next bucket exists and the two bucket counts agree, it hands over
// the earlier count as its result. Otherwise it scans symbols through the
// symbol store read port (1 to 256 symbols scanning up, 0 to 127 when
// scanning down from the next bucket), then drains the scan and hands over
// the result. A query beyond the loaded length goes straight to the result
// hand-over; a clear finishes while the engine stays idle.
// Results wait in an output register.
module bwt_bucketed_rank_query
    import brq_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    brq_req_if.sink          req,
    brq_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [POS_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_LENGTH);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam logic [ADDR_W-1:0] BMASK = ~ADDR_W'(BUCKET_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SNAP, S_INC_RD, S_INC_WR, S_Q_RB, S_Q_RA, S_Q_DEC, S_SCAN, S_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] before_reg, before_next;
    logic               sub_reg, sub_next;
    logic               has_next_reg, has_next_next;
    logic               inc_en_reg, inc_en_next;
    logic               oor_reg, oor_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0]  pidx_reg, pidx_next;
    logic [8:0]         cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [POS_W-1:0]   excl_reg;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_oor_reg, out_oor_next;

    // memories
    logic [SYM_W-1:0]   st_mem [MAX_LENGTH];
    logic [COUNT_W-1:0] bk_mem [MAX_LENGTH];
    logic [COUNT_W-1:0] run_mem [SYMBOLS];
    logic [SYMBOLS-1:0] run_vld;

    logic [SYM_W-1:0]   st_rd_reg;
    logic [COUNT_W-1:0] bk_rd_reg;
    logic [COUNT_W-1:0] run_rd_reg;
    logic               run_rv_reg;

    logic               st_we;
    logic [ADDR_W-1:0]  st_waddr;
    logic               bk_we;
    logic [ADDR_W-1:0]  bk_waddr;
    logic [ADDR_W-1:0]  bk_raddr;
    logic               run_we;
    logic [SYM_W-1:0]   run_addr_w;
    logic [SYM_W-1:0]   run_raddr;
    logic               vld_clr;

    logic [COUNT_W-1:0] run_val;
    logic [ADDR_W-1:0]  pos_a;
    logic [ADDR_W-1:0]  start_a;
    logic [ADDR_W-1:0]  next_a;
    logic               hit;

    assign run_val = run_rv_reg ? run_rd_reg : '0;
    assign pos_a   = ADDR_W'(pos_reg);
    assign start_a = pos_a & BMASK;
    assign next_a  = start_a + ADDR_W'(BUCKET_SIZE);
    assign hit     = pend_reg && (st_rd_reg == sym_reg)
                     && (CMP_W'(pidx_reg) != CMP_W'(excl_reg));

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.rank_count   = out_count_reg;
    assign rsp.out_of_range = out_oor_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        before_next    = before_reg;
        sub_next       = sub_reg;
        has_next_next  = has_next_reg;
        inc_en_next    = inc_en_reg;
        oor_next       = oor_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_oor_next   = out_oor_reg;
        st_we          = 1'b0;
        st_waddr       = len_reg[ADDR_W-1:0];
        bk_we          = 1'b0;
        bk_waddr       = len_reg[ADDR_W-1:0] + pidx_reg;
        bk_raddr       = next_a | ADDR_W'(sym_reg);
        run_we         = 1'b0;
        run_addr_w     = sym_reg;
        run_raddr      = (state_reg == S_INC_RD) ? sym_reg : idx_reg[SYM_W-1:0];
        vld_clr        = 1'b0;

        // drop the result once transferred
        if (rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    sym_next = req.symbol;
                    pos_next = req.position;
                    case (req.op)
                        OP_LOAD:
                        begin
                            if (len_reg != LEN_W'(MAX_LENGTH))
                            begin
                                st_we       = 1'b1;
                                inc_en_next = (CMP_W'(len_reg) != CMP_W'(excl_reg));
                                if (len_reg[7:0] == 8'd0)
                                begin
                                    idx_next   = '0;
                                    cnt_next   = 9'd256;
                                    pend_next  = 1'b0;
                                    state_next = S_SNAP;
                                end
                                else
                                    state_next = S_INC_RD;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (CMP_W'(req.position) >= CMP_W'(len_reg))
                            begin
                                acc_next   = '0;
                                oor_next   = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                oor_next   = 1'b0;
                                state_next = S_Q_RB;
                            end
                        end
                        OP_CLEAR:
                        begin
                            vld_clr  = 1'b1;
                            len_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SNAP:
            begin
                // copy running counts into the bucket table
                if (pend_reg)
                    bk_we = 1'b1;
                pidx_next = idx_reg;
                if (cnt_reg != 9'd0)
                begin
                    idx_next  = idx_reg + ADDR_W'(1);
                    cnt_next  = cnt_reg - 9'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = S_INC_RD;
                end
            end
            S_INC_RD:
                state_next = S_INC_WR;
            S_INC_WR:
            begin
                run_we     = inc_en_reg;
                len_next   = len_reg + LEN_W'(1);
                state_next = S_IDLE;
            end
            S_Q_RB:
            begin
                bk_raddr      = start_a | ADDR_W'(sym_reg);
                has_next_next = (LEN_W'(start_a) + LEN_W'(BUCKET_SIZE)) < len_reg;
                state_next    = S_Q_RA;
            end
            S_Q_RA:
            begin
                before_next = bk_rd_reg;
                state_next  = S_Q_DEC;
            end
            S_Q_DEC:
            begin
                pend_next = 1'b0;
                if (has_next_reg && (bk_rd_reg == before_reg))
                begin
                    acc_next   = before_reg;
                    state_next = S_FIN;
                end
                else if (has_next_reg && pos_reg[7])
                begin
                    acc_next   = bk_rd_reg;
                    sub_next   = 1'b1;
                    idx_next   = pos_a + ADDR_W'(1);
                    cnt_next   = 9'(8'd255 - pos_reg[7:0]);
                    state_next = S_SCAN;
                end
                else
                begin
                    acc_next   = before_reg;
                    sub_next   = 1'b0;
                    idx_next   = start_a;
                    cnt_next   = 9'(pos_reg[7:0]) + 9'd1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // step the accumulator for each fetched symbol that matches, except at the excluded position
                if (hit)
                    acc_next = sub_reg ? acc_reg - COUNT_W'(1) : acc_reg + COUNT_W'(1);
                pidx_next = idx_reg;
                if (cnt_reg != 9'd0)
                begin
                    idx_next  = idx_reg + ADDR_W'(1);
                    cnt_next  = cnt_reg - 9'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hand the result to the output register when it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = acc_reg;
                    out_oor_next   = oor_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            excl_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
                excl_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        pos_reg       <= pos_next;
        acc_reg       <= acc_next;
        before_reg    <= before_next;
        sub_reg       <= sub_next;
        has_next_reg  <= has_next_next;
        inc_en_reg    <= inc_en_next;
        oor_reg       <= oor_next;
        idx_reg       <= idx_next;
        pidx_reg      <= pidx_next;
        out_count_reg <= out_count_next;
        out_oor_reg   <= out_oor_next;
    end

    // symbol store
    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_waddr] <= req.symbol;
        st_rd_reg <= st_mem[idx_reg];
    end

    // bucket count table
    always_ff @(posedge clk)
    begin
        if (bk_we)
            bk_mem[bk_waddr] <= run_val;
        bk_rd_reg <= bk_mem[bk_raddr];
    end

    // running counts
    always_ff @(posedge clk)
    begin
        if (run_we)
            run_mem[run_addr_w] <= run_val + COUNT_W'(1);
        run_rd_reg <= run_mem[run_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_vld    <= '0;
            run_rv_reg <= 1'b0;
        end
        else
        begin
            if (vld_clr)
                run_vld <= '0;
            else if (run_we)
                run_vld[run_addr_w] <= 1'b1;
            run_rv_reg <= run_vld[run_raddr];
        end
    end

    // checks
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.out_of_range |-> rsp.rank_count == '0)
        else $error("out-of-range result with nonzero count");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LENGTH))
        else $error("loaded length beyond store depth");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 9'd256)
        else $error("scan count beyond one bucket");

    a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cnt_reg) != 9'd0)
        else $error("fetch pending without an issued read");

endmodule
